// File: rtl/scd_pkg.sv
// Package for the skipping charset digest: field widths, register indexes,
// reset constants and the charset arithmetic. No dependencies.
`default_nettype none

package scd_pkg;

    localparam int DIGEST_SLOTS_DEF = 16;

    localparam int BYTE_W     = 8;
    localparam int CHAR_W     = 7;
    localparam int CHUNK_W    = 21;
    localparam int PROGRESS_W = 20;
    localparam int SKIP_W     = 30;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 30;
    localparam int SEL_W      = 6;
    localparam int SUM_W      = 13;

    localparam logic [CHAR_W-1:0]  SLOT_INIT   = 7'd48;
    localparam logic [SKIP_W-1:0]  SKIP_LIMIT  = 30'h3FFF_FFFF;
    localparam logic [CHUNK_W-1:0] CHUNK_LIMIT = 21'd1048576;

    localparam logic [CHUNK_W-1:0] CHUNK_LEN_RST    = 21'd1048576;
    localparam logic [SKIP_W-1:0]  SKIP_CAP_RST     = 30'd536870912;
    localparam logic [SKIP_W-1:0]  INITIAL_SKIP_RST = 30'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHUNK_LEN    = 2'd0,
        CFG_SKIP_CAP     = 2'd1,
        CFG_INITIAL_SKIP = 2'd2
    } cfg_index_t;

    // Reduce a 13-bit value modulo 62. Since 64 = 2 (mod 62), fold the
    // upper bits in doubled, then strip multiples of 62 by three compares.
    function automatic logic [SEL_W-1:0] mod62(input logic [SUM_W-1:0] x);
        logic [8:0] s;
        s = {1'b0, x[12:6], 1'b0} + {3'b000, x[5:0]};
        if (s >= 9'd248) s = s - 9'd248;
        if (s >= 9'd124) s = s - 9'd124;
        if (s >= 9'd62)  s = s - 9'd62;
        return s[SEL_W-1:0];
    endfunction

    // Charset lookup: a-z, then A-Z, then 0-9.
    function automatic logic [CHAR_W-1:0] charset_char(input logic [SEL_W-1:0] sel);
        logic [CHAR_W-1:0] c;
        if (sel < 6'd26)
            c = 7'd97 + {1'b0, sel};
        else if (sel < 6'd52)
            c = 7'd65 + {1'b0, sel} - 7'd26;
        else
            c = 7'd48 + {1'b0, sel} - 7'd52;
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/scd_channels.sv
// Handshake channels of the skipping charset digest: byte input, digest
// output and register write. Depends on scd_pkg for field widths.
`default_nettype none

interface scd_in_if;
    logic                       valid;
    logic                       ready;
    logic [scd_pkg::BYTE_W-1:0] data_byte;
    logic                       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface scd_out_if;
    logic                       valid;
    logic                       ready;
    logic [scd_pkg::CHAR_W-1:0] digest_char;
    logic                       digest_end;

    modport source (output valid, output digest_char, output digest_end, input ready);
    modport sink   (input valid, input digest_char, input digest_end, output ready);
endinterface

interface scd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [scd_pkg::CFG_IDX_W-1:0]  index;
    logic [scd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/skipping_charset_digest_top.sv
// Top level of the skipping charset digest: control sequencer, chunk and
// skip counters, slot store in scd_ram. Depends on scd_pkg, scd_channels.
//
// byte_stream carries one file byte per beat, with final_byte on the last
// byte of the file. digest returns DIGEST_SLOTS character beats, slot 0
// first, digest_end high on the last. cfg writes the chunk length (index 0),
// the skip ceiling (index 1) and the initial skip (index 2); other indexes
// are ignored. cfg.ready is always high; write only while the block is idle.
// A byte in a skip gap only counts the gap down. A counted byte goes through
// slot read, charset reduction and write back through the single RAM write
// port. A final byte adds the dump, after the write back or straight after a
// dropped final byte: for each slot a RAM read (S_DUMP_RD), then a load into
// the output register (S_DUMP_LD), which waits while a beat is still stalled.
// byte_stream.ready is low during the read-modify-write and the dump.
// Reset sets the control registers; each slot reads as '0' through its valid
// bit, so no clearing pass is needed. The same clear follows each dump.
// A stalled receiver holds the output register and the dump waits on it;
// once the last character is loaded the block takes new bytes while that
// character still waits.
`default_nettype none

module skipping_charset_digest_top #(
    parameter int DIGEST_SLOTS = scd_pkg::DIGEST_SLOTS_DEF
) (
    input wire logic  clk,
    input wire logic  rst_n,
    scd_in_if.sink    byte_stream,
    scd_out_if.source digest,
    scd_cfg_if.sink   cfg
);
    import scd_pkg::*;

    localparam int SLOT_W = (DIGEST_SLOTS > 1) ? $clog2(DIGEST_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DIGEST_SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_WRITE,
        S_DUMP_RD,
        S_DUMP_LD
    } state_t;

    // Control and counters
    state_t              state_reg;
    logic [BYTE_W-1:0]   byte_reg;
    logic                final_reg;
    logic [SLOT_W-1:0]   ptr_reg;
    logic [SLOT_W-1:0]   dump_idx_reg;
    logic [SLOT_W-1:0]   rd_addr_reg;
    logic [PROGRESS_W-1:0] progress_reg;
    logic [SKIP_W-1:0]   skip_reg;
    logic [SKIP_W-1:0]   drop_reg;
    logic [DIGEST_SLOTS-1:0] slot_valid_reg;
    logic [SEL_W-1:0]    sel_reg;

    // Output register
    logic                out_valid_reg;
    logic [CHAR_W-1:0]   out_char_reg;
    logic                out_end_reg;

    // Configuration registers
    logic [CHUNK_W-1:0]  chunk_len_reg;
    logic [SKIP_W-1:0]   skip_cap_reg;
    logic [SKIP_W-1:0]   init_skip_reg;

    // RAM port signals
    logic                ram_wr_en;
    logic [CHAR_W-1:0]   ram_wr_data;
    logic                ram_rd_en;
    logic [SLOT_W-1:0]   ram_rd_addr;
    logic [CHAR_W-1:0]   ram_rd_data;

    logic                in_accept;
    logic                cfg_accept;
    logic                out_free;
    logic                dump_load;
    logic                dump_last;
    logic                drop_active;
    logic [CHAR_W-1:0]   slot_value;
    logic [SUM_W-1:0]    slot_sum;
    logic [CHUNK_W-1:0]  chunk_limit;
    logic [CHUNK_W-1:0]  progress_inc;
    logic                chunk_done;
    logic [SKIP_W:0]     skip_dbl;
    logic [SKIP_W-1:0]   skip_grown;
    logic [SLOT_W-1:0]   ptr_adv;

    assign byte_stream.ready = (state_reg == S_IDLE);
    assign cfg.ready         = 1'b1;
    assign digest.valid       = out_valid_reg;
    assign digest.digest_char = out_char_reg;
    assign digest.digest_end  = out_end_reg;

    assign in_accept   = byte_stream.valid && byte_stream.ready;
    assign cfg_accept  = cfg.valid && cfg.ready;
    assign out_free    = !out_valid_reg || digest.ready;
    assign drop_active = (drop_reg != '0);
    assign dump_load   = (state_reg == S_DUMP_LD) && out_free;
    assign dump_last   = (dump_idx_reg == LAST_SLOT);

    // Read the slot on a counted byte, or the next slot during the dump.
    assign ram_rd_en   = (in_accept && !drop_active) || (state_reg == S_DUMP_RD);
    assign ram_rd_addr = (state_reg == S_DUMP_RD) ? dump_idx_reg : ptr_reg;

    // A slot never written since the last clear reads as '0'.
    assign slot_value = slot_valid_reg[rd_addr_reg] ? ram_rd_data : SLOT_INIT;
    assign slot_sum   = {1'b0, slot_value, 5'b00000} + {5'b00000, byte_reg};

    assign ram_wr_en   = (state_reg == S_WRITE);
    assign ram_wr_data = charset_char(sel_reg);

    // Chunk boundary: a zero length ends a chunk on every counted byte.
    assign chunk_limit  = (chunk_len_reg > CHUNK_LIMIT) ? CHUNK_LIMIT : chunk_len_reg;
    assign progress_inc = {1'b0, progress_reg} + 21'd1;
    assign chunk_done   = (progress_inc >= chunk_limit);

    // Double the skip, saturating at the 30-bit ceiling.
    assign skip_dbl   = {skip_reg, 1'b0};
    assign skip_grown = skip_dbl[SKIP_W] ? SKIP_LIMIT : skip_dbl[SKIP_W-1:0];

    assign ptr_adv = (ptr_reg == LAST_SLOT) ? '0 : ptr_reg + SLOT_W'(1);

    scd_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DIGEST_SLOTS)
    ) u_slots (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ptr_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            byte_reg <= byte_stream.data_byte;
        end
        if (ram_rd_en)
        begin
            rd_addr_reg <= ram_rd_addr;
        end
        if (state_reg == S_CALC)
        begin
            sel_reg <= mod62(slot_sum);
        end
        if (dump_load)
        begin
            out_char_reg <= slot_value;
            out_end_reg  <= dump_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            final_reg      <= 1'b0;
            ptr_reg        <= '0;
            dump_idx_reg   <= '0;
            progress_reg   <= '0;
            skip_reg       <= INITIAL_SKIP_RST;
            drop_reg       <= '0;
            slot_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
            chunk_len_reg  <= CHUNK_LEN_RST;
            skip_cap_reg   <= SKIP_CAP_RST;
            init_skip_reg  <= INITIAL_SKIP_RST;
        end
        else
        begin
            // Drop the output beat once taken; a new load below overrides.
            if (digest.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        final_reg    <= byte_stream.final_byte;
                        dump_idx_reg <= '0;
                        if (drop_active)
                        begin
                            // Byte falls in a skip gap: count it down, no slot update.
                            drop_reg  <= drop_reg - SKIP_W'(1);
                            state_reg <= byte_stream.final_byte ? S_DUMP_RD : S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_CALC;
                        end
                    end
                end
                S_CALC:
                begin
                    state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    slot_valid_reg[ptr_reg] <= 1'b1;
                    ptr_reg <= ptr_adv;
                    if (chunk_done)
                    begin
                        progress_reg <= '0;
                        drop_reg     <= skip_reg;
                        if (skip_reg < skip_cap_reg)
                        begin
                            skip_reg <= skip_grown;
                        end
                    end
                    else
                    begin
                        progress_reg <= progress_inc[PROGRESS_W-1:0];
                    end
                    state_reg <= final_reg ? S_DUMP_RD : S_IDLE;
                end
                S_DUMP_RD:
                begin
                    state_reg <= S_DUMP_LD;
                end
                S_DUMP_LD:
                begin
                    if (dump_load)
                    begin
                        out_valid_reg <= 1'b1;
                        if (dump_last)
                        begin
                            // Digest out: clear the file state and reload the initial skip for the next file.
                            slot_valid_reg <= '0;
                            ptr_reg        <= '0;
                            progress_reg   <= '0;
                            drop_reg       <= '0;
                            skip_reg       <= init_skip_reg;
                            state_reg      <= S_IDLE;
                        end
                        else
                        begin
                            dump_idx_reg <= dump_idx_reg + SLOT_W'(1);
                            state_reg    <= S_DUMP_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // Register writes; initial_skip also reloads the running skip.
            if (cfg_accept)
            begin
                unique case (cfg.index)
                    CFG_CHUNK_LEN: chunk_len_reg <= cfg.data[CHUNK_W-1:0];
                    CFG_SKIP_CAP:  skip_cap_reg  <= cfg.data[SKIP_W-1:0];
                    CFG_INITIAL_SKIP:
                    begin
                        init_skip_reg <= cfg.data[SKIP_W-1:0];
                        skip_reg      <= cfg.data[SKIP_W-1:0];
                    end
                    default: ;
                endcase
            end
        end
    end

    // After the last slot is loaded for output, the file state is clear.
    a_clear_after_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (dump_load && dump_last) |=>
            (slot_valid_reg == '0 && ptr_reg == '0 && progress_reg == '0
             && drop_reg == '0))
        else $error("file state not cleared after digest");

    // A byte in a skip gap takes one count off the gap and no slot change.
    a_drop_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && drop_active) |=>
            (drop_reg == $past(drop_reg) - SKIP_W'(1) && $stable(slot_valid_reg)))
        else $error("skip gap count wrong");

    // The write back always follows the reduction step.
    a_write_after_calc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |-> ($past(state_reg) == S_CALC))
        else $error("slot write without reduction");

    // An output load never overwrites a beat that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !digest.ready) |=> $stable(out_char_reg) && out_valid_reg)
        else $error("digest beat overwritten while stalled");

endmodule

`default_nettype wire

// File: rtl/scd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module scd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [ADDR_W-1:0]        wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [ADDR_W-1:0]        rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
